>>> sv/tfa_pkg.sv
package tfa_pkg;

  localparam int MAX_PIXELS_DEF = 65536;
  localparam int WINDOW_MAX_DEF = 16;
  localparam int COUNT_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 32;
  localparam int QUOT_BITS  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVG_MODE      = 2'd0,
    CFG_WINDOW_FRAMES = 2'd1,
    CFG_FRAME_PIXELS  = 2'd2,
    CFG_ADD_RESTART   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_UNIFORM = 2'd0,
    MODE_FADING  = 2'd1,
    MODE_SLIDING = 2'd2,
    MODE_ADD     = 2'd3
  } avg_mode_t;

  localparam int WINDOW_RESET  = 10;
  localparam int FRAMES_RESET  = 65536;
  localparam int RESTART_RESET = 10;

  // Side information that rides along with a sum through the divider.
  typedef struct packed {
    logic             use_div;
    logic [PIX_W-1:0] direct;
    logic             last;
  } div_info_t;

endpackage

>>> sv/tfa_ram.sv
module tfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tfa_div.sv
module tfa_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          in_rem,
  input  logic [31:0]          in_div,
  input  tfa_pkg::div_info_t   in_info,
  output logic                 out_valid,
  output logic [7:0]           out_q,
  output tfa_pkg::div_info_t   out_info
);
  import tfa_pkg::*;

  // One quotient bit per stage, most significant first. The quotient is
  // known to fit in QUOT_BITS bits for every history the block can build.
  logic             vld  [QUOT_BITS+1];
  logic [SUM_W-1:0] rem  [QUOT_BITS+1];
  logic [SUM_W-1:0] dvs  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quo [QUOT_BITS+1];
  div_info_t        info [QUOT_BITS+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_rem;
  assign dvs[0]  = in_div;
  assign quo[0]  = '0;
  assign info[0] = in_info;

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    localparam int B = QUOT_BITS - 1 - k;
    logic [SUM_W+QUOT_BITS-1:0] shifted;
    logic                       take;
    assign shifted = {{QUOT_BITS{1'b0}}, dvs[k]} << B;
    assign take    = {{QUOT_BITS{1'b0}}, rem[k]} >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1]  <= take ? rem[k] - shifted[SUM_W-1:0] : rem[k];
      dvs[k+1]  <= dvs[k];
      quo[k+1]  <= quo[k] | (QUOT_BITS'(take) << B);
      info[k+1] <= info[k];
    end
  end

  assign out_valid = vld[QUOT_BITS];
  assign out_q     = quo[QUOT_BITS];
  assign out_info  = info[QUOT_BITS];

endmodule

>>> sv/temporal_frame_averager.sv
// Temporal frame averager for 8-bit luminance video.
// Pixels enter on the input channel (pixel, in_valid, in_ready) in raster
// order, frame after frame; every request yields one result on the output
// channel (avg_pixel, frame_end, out_valid, out_ready), in order. frame_end
// marks the last pixel of each frame.
// One pixel is taken per cycle while in_ready is high. A pixel reads its
// stored sum, history and shown value from synchronous memories, updates
// them in the next cycle, then passes through an eight-stage divider into
// the output queue. A sixteen-entry output queue absorbs stalls: the input
// keeps accepting while results in flight plus queued stay below sixteen,
// so a stalled receiver holds the input off only once that many results
// are pending.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// the user must make them only while idle; the block does not enforce it.
// Writing the mode, window or frame size restarts the averaging history:
// the next frame passes through and reloads the stores. Reset does the same
// and loads register defaults; memories stay uncleared, written before use.
module temporal_frame_averager #(
  parameter int MAX_PIXELS = tfa_pkg::MAX_PIXELS_DEF,
  parameter int WINDOW_MAX = tfa_pkg::WINDOW_MAX_DEF,
  parameter int COUNT_BITS = tfa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    avg_pixel,
  output logic                          frame_end,
  input  logic                          cfg_we,
  input  logic [tfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tfa_pkg::*;

  localparam int POS_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int FP_W   = $clog2(MAX_PIXELS + 1);
  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
  localparam int PAST_W = SLOT_W + POS_W;
  localparam int Q_DEPTH = 16;
  localparam int Q_W     = $clog2(Q_DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;
  localparam int WIN_RST = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;
  localparam int FP_RST  = (FRAMES_RESET > MAX_PIXELS) ? MAX_PIXELS : FRAMES_RESET;

  // Configuration registers.
  avg_mode_t       avg_mode;
  logic [WIN_W-1:0] window_frames;
  logic [FP_W-1:0] frame_pixels;
  logic [7:0]      add_restart_count;

  // Sequencing state kept in flip-flops.
  logic [COUNT_BITS-1:0] frame_count;
  logic [SLOT_W-1:0]     ring_slot;
  logic [7:0]            add_frames;
  logic [POS_W-1:0]      pixel_position;

  logic in_fire;
  logic [Q_W:0] pending;
  assign in_ready = pending < (Q_W+1)'(Q_DEPTH);
  assign in_fire  = in_valid && in_ready;

  // Front stage: position, slot and mode decisions for the arriving pixel.
  logic [POS_W-1:0]  pos_eff;
  logic [SLOT_W-1:0] slot_eff;
  logic              last;
  logic              first;
  logic [SLOT_W-1:0] slot_next;
  logic [7:0]        add_next;
  logic [8:0]        add_inc;
  logic [31:0]       divisor;

  always_comb begin
    pos_eff  = (32'(pixel_position) >= 32'(frame_pixels)) ? '0 : pixel_position;
    slot_eff = (32'(ring_slot) >= 32'(window_frames)) ? '0 : ring_slot;
    last     = (32'(pos_eff) + 32'd1) >= 32'(frame_pixels);
    first    = frame_count == '0;
    slot_next = ((32'(slot_eff) + 32'd1) >= 32'(window_frames)) ? '0
              : SLOT_W'(32'(slot_eff) + 32'd1);
    add_inc  = {1'b0, add_frames} + 9'd1;
    add_next = add_frames;
    if (!first && avg_mode == MODE_ADD && pos_eff == '0) begin
      add_next = (add_inc > {1'b0, add_restart_count}) ? 8'd0 : add_inc[7:0];
    end
    divisor = 32'(frame_count) + 32'd1;
    if (avg_mode == MODE_UNIFORM && frame_count == COUNT_SAT) begin
      divisor = 32'(COUNT_SAT);
    end else if (avg_mode == MODE_SLIDING &&
                 32'(frame_count) >= 32'(window_frames)) begin
      divisor = 32'(window_frames);
    end
  end

  // Configuration writes and state updates.
  logic [31:0] cfg_wide;
  assign cfg_wide = 32'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_mode          <= MODE_UNIFORM;
      window_frames     <= WIN_W'(WIN_RST);
      frame_pixels      <= FP_W'(FP_RST);
      add_restart_count <= 8'(RESTART_RESET);
      frame_count       <= '0;
      ring_slot         <= '0;
      add_frames        <= '0;
      pixel_position    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_AVG_MODE: begin
          avg_mode <= avg_mode_t'(cfg_data[1:0]);
        end
        CFG_WINDOW_FRAMES: begin
          if (cfg_data[4:0] == 5'd0) begin
            window_frames <= WIN_W'(1);
          end else if (32'(cfg_data[4:0]) > 32'(WINDOW_MAX)) begin
            window_frames <= WIN_W'(WINDOW_MAX);
          end else begin
            window_frames <= WIN_W'(32'(cfg_data[4:0]));
          end
        end
        CFG_FRAME_PIXELS: begin
          if (cfg_wide == 32'd0) begin
            frame_pixels <= FP_W'(1);
          end else if (cfg_wide > 32'(MAX_PIXELS)) begin
            frame_pixels <= FP_W'(MAX_PIXELS);
          end else begin
            frame_pixels <= FP_W'(cfg_wide);
          end
        end
        CFG_ADD_RESTART: begin
          add_restart_count <= cfg_data[7:0];
        end
        default: ;
      endcase
      // Every register but the restart count clears the history.
      if (cfg_index_t'(cfg_index) != CFG_ADD_RESTART) begin
        frame_count    <= '0;
        ring_slot      <= '0;
        pixel_position <= '0;
      end
    end else if (in_fire) begin
      add_frames <= add_next;
      if (last) begin
        pixel_position <= '0;
        ring_slot      <= slot_next;
        if (frame_count != COUNT_SAT) begin
          frame_count <= frame_count + 1'b1;
        end
      end else begin
        pixel_position <= POS_W'(32'(pos_eff) + 32'd1);
        ring_slot      <= slot_eff;
      end
    end
  end

  // Read stage: pixel registered while its memory entries are read.
  logic              s1_valid;
  logic [7:0]        s1_px;
  logic [POS_W-1:0]  s1_pos;
  logic [PAST_W-1:0] s1_paddr;
  logic              s1_first;
  avg_mode_t         s1_mode;
  logic              s1_sat;
  logic              s1_full;
  logic              s1_addz;
  logic              s1_last;
  logic [31:0]       s1_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
    s1_px    <= pixel;
    s1_pos   <= pos_eff;
    s1_paddr <= {slot_eff, pos_eff};
    s1_first <= first;
    s1_mode  <= avg_mode;
    s1_sat   <= frame_count == COUNT_SAT;
    s1_full  <= 32'(frame_count) >= 32'(window_frames);
    s1_addz  <= add_next == 8'd0;
    s1_last  <= last;
    s1_div   <= divisor;
  end

  logic [SUM_W-1:0] sum_q, sum_w, sum_rd, fwd_sum;
  logic [7:0]       past_q, past_rd, fwd_past;
  logic [7:0]       shown_q, shown_w, shown_rd, fwd_shown;
  logic             sum_we, past_we, shown_we;
  logic             hit_sum, hit_past, hit_shown;

  tfa_ram #(.WIDTH(SUM_W), .DEPTH(2**POS_W)) u_sums (
    .clk(clk), .we(sum_we), .waddr(s1_pos), .wdata(sum_w),
    .raddr(pos_eff), .rdata(sum_q)
  );

  tfa_ram #(.WIDTH(8), .DEPTH(2**PAST_W)) u_past (
    .clk(clk), .we(past_we), .waddr(s1_paddr), .wdata(s1_px),
    .raddr({slot_eff, pos_eff}), .rdata(past_q)
  );

  tfa_ram #(.WIDTH(8), .DEPTH(2**POS_W)) u_shown (
    .clk(clk), .we(shown_we), .waddr(s1_pos), .wdata(shown_w),
    .raddr(pos_eff), .rdata(shown_q)
  );

  // A pixel read in the same cycle as a write to its entry takes the new
  // value from the forwarding registers instead of the stale memory word.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_sum   <= 1'b0;
      hit_past  <= 1'b0;
      hit_shown <= 1'b0;
    end else begin
      hit_sum   <= in_fire && sum_we && s1_pos == pos_eff;
      hit_past  <= in_fire && past_we && s1_paddr == {slot_eff, pos_eff};
      hit_shown <= in_fire && shown_we && s1_pos == pos_eff;
    end
    fwd_sum   <= sum_w;
    fwd_past  <= s1_px;
    fwd_shown <= shown_w;
  end

  assign sum_rd   = hit_sum ? fwd_sum : sum_q;
  assign past_rd  = hit_past ? fwd_past : past_q;
  assign shown_rd = hit_shown ? fwd_shown : shown_q;

  // Modify stage: new sum and shown value, plus the divider request.
  logic [SUM_W+1:0] fade;
  div_info_t        d_info;

  always_comb begin
    fade     = ({2'b00, sum_rd} + {1'b0, sum_rd, 1'b0} + (SUM_W+2)'(s1_px)) >> 2;
    sum_w    = sum_rd + SUM_W'(s1_px);
    shown_w  = s1_px;
    sum_we   = 1'b0;
    past_we  = 1'b0;
    shown_we = 1'b0;
    d_info.use_div = 1'b0;
    d_info.direct  = s1_px;
    d_info.last    = s1_last;
    if (s1_first) begin
      sum_w    = SUM_W'(s1_px);
      sum_we   = s1_valid;
      past_we  = s1_valid;
      shown_we = s1_valid;
    end else begin
      unique case (s1_mode)
        MODE_UNIFORM: begin
          d_info.use_div = 1'b1;
          if (s1_sat) begin
            sum_w = sum_rd;
          end else begin
            sum_we = s1_valid;
          end
        end
        MODE_FADING: begin
          sum_w         = fade[SUM_W-1:0];
          sum_we        = s1_valid;
          d_info.direct = fade[7:0];
        end
        MODE_SLIDING: begin
          if (s1_full) begin
            sum_w = sum_rd - SUM_W'(past_rd) + SUM_W'(s1_px);
          end
          sum_we         = s1_valid;
          past_we        = s1_valid;
          d_info.use_div = 1'b1;
        end
        MODE_ADD: begin
          shown_w       = s1_addz ? s1_px : shown_rd + s1_px;
          shown_we      = s1_valid;
          d_info.direct = shown_w;
        end
        default: ;
      endcase
    end
  end

  logic       dv_valid;
  logic [7:0] dv_q;
  div_info_t  dv_info;

  tfa_div u_div (
    .clk(clk), .rst(rst), .in_valid(s1_valid), .in_rem(sum_w), .in_div(s1_div),
    .in_info(d_info), .out_valid(dv_valid), .out_q(dv_q), .out_info(dv_info)
  );

  // Output queue. Results never need to stall inside the pipeline because
  // the input is held off once the queue plus the pipeline could overflow.
  logic [8:0]   q_mem [Q_DEPTH];
  logic [Q_W-1:0] q_wr, q_rd;
  logic [Q_W:0] q_cnt;
  logic         q_pop;

  assign out_valid = q_cnt != '0;
  assign q_pop     = out_valid && out_ready;
  assign avg_pixel = q_mem[q_rd][7:0];
  assign frame_end = q_mem[q_rd][8];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_cnt   <= '0;
      pending <= '0;
    end else begin
      if (dv_valid) begin
        q_wr <= q_wr + 1'b1;
      end
      if (q_pop) begin
        q_rd <= q_rd + 1'b1;
      end
      q_cnt   <= q_cnt + (Q_W+1)'(dv_valid) - (Q_W+1)'(q_pop);
      pending <= pending + (Q_W+1)'(in_fire) - (Q_W+1)'(q_pop);
    end
    if (dv_valid) begin
      q_mem[q_wr] <= {dv_info.last, dv_info.use_div ? dv_q : dv_info.direct};
    end
  end

`ifndef NO_ASSERTIONS
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (Q_W+1)'(Q_DEPTH))
    else $error("more requests in flight than the output queue holds");
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    dv_valid |-> (q_cnt < (Q_W+1)'(Q_DEPTH) || q_pop))
    else $error("result written into a full output queue");
  a_queue_within_pending: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= pending)
    else $error("output queue holds more results than requests taken");
`endif

endmodule
